>>> rtl/gtl_pkg.sv
package gtl_pkg;

    localparam int COORD_BITS     = 11;
    localparam int CUR_BITS       = COORD_BITS + 1;
    localparam int GLYPHS_PER_ROW = 190;
    localparam int FONT_BITS      = 6;
    localparam int INDEX_BITS     = 15;
    localparam int OFFSET_BITS    = 22;
    localparam int CFG_IDX_BITS   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AREA_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FONT_SIZE    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OVERLAY_MODE = 2'd3;

    localparam logic [COORD_BITS-1:0] AREA_WIDTH_RESET  = COORD_BITS'(480);
    localparam logic [COORD_BITS-1:0] AREA_HEIGHT_RESET = COORD_BITS'(272);
    localparam logic [FONT_BITS-1:0]  FONT_SIZE_RESET   = 6'd16;

    // Input operations.
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Result kinds.
    localparam logic [2:0] KIND_ASCII       = 3'd0;
    localparam logic [2:0] KIND_GLYPH       = 3'd1;
    localparam logic [2:0] KIND_INVALID     = 3'd2;
    localparam logic [2:0] KIND_UNSUPPORTED = 3'd3;
    localparam logic [2:0] KIND_STOPPED     = 3'd4;

    // Byte values with a special meaning.
    localparam logic [7:0] CHAR_NUL      = 8'h00;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] ASCII_MAX     = 8'h80;
    localparam logic [7:0] LEAD_MIN      = 8'h81;
    localparam logic [7:0] TRAIL_MIN     = 8'h40;
    localparam logic [7:0] TRAIL_GAP     = 8'h7F;
    localparam logic [7:0] TRAIL_HI_BASE = 8'h41;
    localparam logic [7:0] CODE_BAD      = 8'hFF;

    localparam logic [FONT_BITS-1:0] FONT_16 = 6'd16;
    localparam logic [FONT_BITS-1:0] FONT_24 = 6'd24;
    localparam logic [FONT_BITS-1:0] FONT_32 = 6'd32;

    typedef struct packed {
        logic                  op;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [7:0]            text_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]             kind;
        logic [11:0]            draw_x;
        logic [11:0]            draw_y;
        logic [15:0]            char_code;
        logic [OFFSET_BITS-1:0] glyph_offset;
        logic [7:0]             glyph_bytes;
        logic                   overlay;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic load_direct;
        logic load_glyph;
    } ctrl_cmd_t;

    // What the offered item will produce, from the datapath to the controller.
    typedef struct packed {
        logic direct_result;
        logic glyph_result;
    } dp_status_t;

    // Bytes per glyph for the supported double-byte sizes.
    function automatic logic [7:0] glyph_size_bytes(input logic [FONT_BITS-1:0] fs);
        logic [7:0] nb;
        unique case (fs)
            FONT_16: nb = 8'd32;
            FONT_24: nb = 8'd72;
            FONT_32: nb = 8'd128;
            default: nb = 8'd0;
        endcase
        return nb;
    endfunction

endpackage

>>> rtl/gtl_ctrl.sv
module gtl_ctrl
    import gtl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_MUL  = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    // The output register is free when empty or being emptied this cycle.
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.take        = in_valid && in_ready;
        cmd.load_direct = cmd.take && status.direct_result;
        cmd.load_glyph  = (state_reg == S_MUL);
        state_next      = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.take && status.glyph_result)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || cmd.load_direct
                         || cmd.load_glyph;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/gtl_datapath.sv
module gtl_datapath
    import gtl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  in_item_t                in_item,
    output out_item_t               out_item,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]   cfg_data,
    input  ctrl_cmd_t               cmd,
    output dp_status_t              status
);

    // Configuration registers.
    logic [COORD_BITS-1:0] area_width_reg, area_height_reg;
    logic [FONT_BITS-1:0]  font_size_reg;
    logic                  overlay_mode_reg;

    // Layout state.
    logic [CUR_BITS-1:0]   cursor_x_reg, cursor_x_next;
    logic [CUR_BITS-1:0]   cursor_y_reg, cursor_y_next;
    logic [COORD_BITS-1:0] origin_x_reg, origin_x_next;
    logic [COORD_BITS-1:0] origin_y_reg, origin_y_next;
    logic                  lead_pending_reg, lead_pending_next;
    logic [7:0]            lead_byte_reg, lead_byte_next;
    logic                  skip_next_reg, skip_next_next;
    logic                  halted_reg, halted_next;

    // Glyph stage registers, consumed in the multiply cycle.
    logic [2:0]            g_kind_reg;
    logic [11:0]           g_x_reg, g_y_reg;
    logic [15:0]           g_code_reg;
    logic [INDEX_BITS-1:0] g_index_reg;
    logic [7:0]            g_nbytes_reg;

    out_item_t out_reg;

    // Placement: wrap check and bottom check.
    logic [FONT_BITS-1:0]  adv;
    logic [CUR_BITS:0]     x_end;
    logic [CUR_BITS:0]     x_lim;
    logic                  wrap;
    logic [CUR_BITS-1:0]   x_pl;
    logic [CUR_BITS:0]     y_pl;
    logic [CUR_BITS+1:0]   y_end;
    logic [CUR_BITS+1:0]   y_lim;
    logic                  stop;
    logic [CUR_BITS:0]     cr_y;

    // Glyph decode.
    logic [7:0]            qh, ql, col, row;
    logic                  size_ok, code_ok;
    logic [INDEX_BITS-1:0] index;
    logic [2:0]            glyph_kind;
    logic [INDEX_BITS+7:0] offset_full;

    // Direct result payload.
    logic [2:0]            d_kind;
    logic [15:0]           d_code;
    logic                  glyph_load;

    assign adv   = lead_pending_reg ? font_size_reg : (font_size_reg >> 1);
    assign x_end = {1'b0, cursor_x_reg} + (CUR_BITS+1)'(adv);
    assign x_lim = (CUR_BITS+1)'(origin_x_reg) + (CUR_BITS+1)'(area_width_reg);
    assign wrap  = x_end > x_lim;
    assign x_pl  = wrap ? CUR_BITS'(origin_x_reg) : cursor_x_reg;
    assign y_pl  = wrap ? ({1'b0, cursor_y_reg} + (CUR_BITS+1)'(font_size_reg))
                        : {1'b0, cursor_y_reg};
    assign y_end = {1'b0, y_pl} + (CUR_BITS+2)'(font_size_reg);
    assign y_lim = (CUR_BITS+2)'(origin_y_reg) + (CUR_BITS+2)'(area_height_reg);
    assign stop  = y_end > y_lim;
    assign cr_y  = y_pl + (CUR_BITS+1)'(font_size_reg);

    assign qh      = lead_byte_reg;
    assign ql      = in_item.text_byte;
    assign size_ok = (font_size_reg == FONT_16) || (font_size_reg == FONT_24)
                     || (font_size_reg == FONT_32);
    assign code_ok = (qh >= LEAD_MIN) && (ql >= TRAIL_MIN) && (ql != CODE_BAD)
                     && (qh != CODE_BAD);
    assign col     = (ql < TRAIL_GAP) ? (ql - TRAIL_MIN) : (ql - TRAIL_HI_BASE);
    assign row     = qh - LEAD_MIN;
    assign index   = INDEX_BITS'(GLYPHS_PER_ROW * 32'(row)) + INDEX_BITS'(col);

    always_comb
    begin
        priority if (!size_ok)
        begin
            glyph_kind = KIND_UNSUPPORTED;
        end
        else if (!code_ok)
        begin
            glyph_kind = KIND_INVALID;
        end
        else
        begin
            glyph_kind = KIND_GLYPH;
        end
    end

    // Item sequencing: the order of the checks follows the byte protocol.
    always_comb
    begin
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        origin_x_next     = origin_x_reg;
        origin_y_next     = origin_y_reg;
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        skip_next_next    = skip_next_reg;
        halted_next       = halted_reg;
        status            = '0;
        d_kind            = KIND_ASCII;
        d_code            = {8'd0, in_item.text_byte};
        glyph_load        = 1'b0;
        priority if (in_item.op == OP_START)
        begin
            origin_x_next     = in_item.start_x;
            origin_y_next     = in_item.start_y;
            cursor_x_next     = CUR_BITS'(in_item.start_x);
            cursor_y_next     = CUR_BITS'(in_item.start_y);
            lead_pending_next = 1'b0;
            skip_next_next    = 1'b0;
            halted_next       = 1'b0;
        end
        else if (halted_reg)
        begin
            // Bytes after the end of a string are ignored.
        end
        else if (in_item.text_byte == CHAR_NUL)
        begin
            halted_next       = 1'b1;
            lead_pending_next = 1'b0;
            skip_next_next    = 1'b0;
        end
        else if (skip_next_reg)
        begin
            skip_next_next = 1'b0;
        end
        else if (!lead_pending_reg)
        begin
            priority if (in_item.text_byte > ASCII_MAX)
            begin
                lead_pending_next = 1'b1;
                lead_byte_next    = in_item.text_byte;
            end
            else if (stop)
            begin
                halted_next          = 1'b1;
                d_kind               = KIND_STOPPED;
                status.direct_result = 1'b1;
            end
            else if (in_item.text_byte == CHAR_CR)
            begin
                cursor_x_next  = CUR_BITS'(origin_x_reg);
                cursor_y_next  = cr_y[CUR_BITS-1:0];
                skip_next_next = 1'b1;
            end
            else
            begin
                d_kind               = KIND_ASCII;
                status.direct_result = 1'b1;
                cursor_x_next        = x_pl + CUR_BITS'(font_size_reg >> 1);
                cursor_y_next        = y_pl[CUR_BITS-1:0];
            end
        end
        else
        begin
            lead_pending_next = 1'b0;
            d_code            = {qh, ql};
            if (stop)
            begin
                halted_next          = 1'b1;
                d_kind               = KIND_STOPPED;
                status.direct_result = 1'b1;
            end
            else
            begin
                status.glyph_result = 1'b1;
                glyph_load          = 1'b1;
                cursor_x_next       = x_pl + CUR_BITS'(font_size_reg);
                cursor_y_next       = y_pl[CUR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_width_reg   <= AREA_WIDTH_RESET;
            area_height_reg  <= AREA_HEIGHT_RESET;
            font_size_reg    <= FONT_SIZE_RESET;
            overlay_mode_reg <= 1'b0;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= '0;
            skip_next_reg    <= 1'b0;
            halted_reg       <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_AREA_WIDTH:   area_width_reg   <= cfg_data;
                    CFG_AREA_HEIGHT:  area_height_reg  <= cfg_data;
                    CFG_FONT_SIZE:    font_size_reg    <= cfg_data[FONT_BITS-1:0];
                    CFG_OVERLAY_MODE: overlay_mode_reg <= cfg_data[0];
                    default:          overlay_mode_reg <= overlay_mode_reg;
                endcase
            end
            if (cmd.take)
            begin
                cursor_x_reg     <= cursor_x_next;
                cursor_y_reg     <= cursor_y_next;
                origin_x_reg     <= origin_x_next;
                origin_y_reg     <= origin_y_next;
                lead_pending_reg <= lead_pending_next;
                lead_byte_reg    <= lead_byte_next;
                skip_next_reg    <= skip_next_next;
                halted_reg       <= halted_next;
            end
        end
    end

    // First half of the glyph offset: row and column index and the glyph size.
    always_ff @(posedge clk)
    begin
        if (cmd.take && glyph_load)
        begin
            g_kind_reg <= glyph_kind;
            g_x_reg    <= x_pl;
            g_y_reg    <= y_pl[CUR_BITS-1:0];
            g_code_reg <= {qh, ql};
            if (glyph_kind == KIND_GLYPH)
            begin
                g_index_reg  <= index;
                g_nbytes_reg <= glyph_size_bytes(font_size_reg);
            end
            else
            begin
                g_index_reg  <= '0;
                g_nbytes_reg <= '0;
            end
        end
    end

    assign offset_full = (INDEX_BITS+8)'(g_index_reg) * (INDEX_BITS+8)'(g_nbytes_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_direct)
        begin
            out_reg.kind         <= d_kind;
            out_reg.draw_x       <= x_pl;
            out_reg.draw_y       <= y_pl[CUR_BITS-1:0];
            out_reg.char_code    <= d_code;
            out_reg.glyph_offset <= '0;
            out_reg.glyph_bytes  <= '0;
            out_reg.overlay      <= overlay_mode_reg;
        end
        else if (cmd.load_glyph)
        begin
            out_reg.kind         <= g_kind_reg;
            out_reg.draw_x       <= g_x_reg;
            out_reg.draw_y       <= g_y_reg;
            out_reg.char_code    <= g_code_reg;
            out_reg.glyph_offset <= offset_full[OFFSET_BITS-1:0];
            out_reg.glyph_bytes  <= g_nbytes_reg;
            out_reg.overlay      <= overlay_mode_reg;
        end
    end

    assign out_item = out_reg;

endmodule

>>> rtl/gbk_text_layout_engine.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_item  (op, start_x, start_y, text_byte)
// out       output     out_valid / out_ready  out_item (kind, draw_x, draw_y, char_code,
//                                                       glyph_offset, glyph_bytes, overlay)
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// A start item or an ASCII, control or lead byte is finished when it is accepted.
// For a placed trail byte, the cycle it is accepted in finds the glyph index,
// and the next cycle multiplies it by the glyph size into the output register.
// A new item is taken only while the output register is empty or drains in the
// same cycle, so a stalled output holds the input off while a result waits.
// After reset the layout is stopped until the first start item; the
// configuration registers return to their documented defaults.
module gbk_text_layout_engine
    import gtl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_item_t                in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output out_item_t               out_item,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]   cfg_data
);

    // The controller owns the handshakes and the glyph sequence with its multiply state;
    // the datapath owns the layout state, the configuration and the payload.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    gtl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath reports whether the offered item yields a result at once
    // (ASCII or stop) or after the multiply cycle (any trail byte that is
    // placed without stopping).
    gtl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> rtl/gtl_checker.sv
module gtl_checker
    import gtl_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input in_item_t                in_item,
    input logic                    out_valid,
    input logic                    out_ready,
    input out_item_t               out_item
);

    // A result that waits must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    // A start item never yields a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_item.op == OP_START && !out_valid |=> !out_valid)
        else $error("start item produced a result");

    // Only a drawable glyph carries an offset and a size.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind != KIND_GLYPH |->
            out_item.glyph_offset == '0 && out_item.glyph_bytes == '0)
        else $error("offset or size on a result that is not a glyph");

    // A drawable glyph has one of the three supported sizes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_GLYPH |->
            out_item.glyph_bytes == 8'd32 || out_item.glyph_bytes == 8'd72
            || out_item.glyph_bytes == 8'd128)
        else $error("glyph with an unsupported byte count");

endmodule

bind gbk_text_layout_engine gtl_checker u_gtl_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import gtl_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    // A trail byte passes through the multiply state, so SETTLE_CYCLES covers any
    // work still in flight after the last draw command has come out.
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int TAIL_ITEMS    = 150;
    localparam int CYCLE_LIMIT   = 600000;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    in_item_t                in_item;
    logic                    out_valid;
    logic                    out_ready;
    out_item_t               out_item;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [COORD_BITS-1:0]   cfg_data;

    gbk_text_layout_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the layout registers, updated as each write lands.
    int unsigned lay_width;
    int unsigned lay_height;
    int unsigned lay_font;
    logic        lay_overlay;

    // Layout state as the block should hold it after every accepted item.
    logic [CUR_BITS-1:0]   pen_x;
    logic [CUR_BITS-1:0]   pen_y;
    logic [COORD_BITS-1:0] org_x;
    logic [COORD_BITS-1:0] org_y;
    logic                  lead_held;
    logic [7:0]            lead_val;
    logic                  drop_next;
    logic                  stopped;

    // Draw commands predicted but not yet seen on the output, oldest first.
    out_item_t draws_due[$];
    out_item_t due;

    int errors;
    int live_items;
    int cycles;
    bit idle_off;
    int sender_calm;
    int ready_stall;
    int ready_calm;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void reset_layout_model();
        lay_width   = AREA_WIDTH_RESET;
        lay_height  = AREA_HEIGHT_RESET;
        lay_font    = FONT_SIZE_RESET;
        lay_overlay = 1'b0;
        pen_x       = '0;
        pen_y       = '0;
        org_x       = '0;
        org_y       = '0;
        lead_held   = 1'b0;
        lead_val    = '0;
        drop_next   = 1'b0;
        // Nothing is laid out until the first start item arrives.
        stopped     = 1'b1;
    endfunction

    // Moves the pen to the next line when a character of width adv would cross
    // the right edge, then tells whether the character would cross the bottom.
    function automatic bit wrap_hits_bottom(input int unsigned adv,
                                            inout int unsigned x,
                                            inout int unsigned y);
        if (x + adv > org_x + lay_width)
        begin
            y = y + lay_font;
            x = org_x;
        end
        return (y + lay_font > org_y + lay_height);
    endfunction

    function automatic out_item_t draw_cmd(input logic [2:0] kind,
                                           input int unsigned x, y,
                                           input logic [15:0] code,
                                           input int unsigned offs, nbytes);
        out_item_t c;
        c.kind         = kind;
        c.draw_x       = 12'(x);
        c.draw_y       = 12'(y);
        c.char_code    = code;
        c.glyph_offset = OFFSET_BITS'(offs);
        c.glyph_bytes  = 8'(nbytes);
        c.overlay      = lay_overlay;
        return c;
    endfunction

    // Advances the layout by one accepted item. Returns 1 with the draw
    // command in cmd when the item produces one.
    function automatic bit layout_step(input in_item_t it, output out_item_t cmd);
        int unsigned x;
        int unsigned y;
        int unsigned col;
        int unsigned nbytes;
        int unsigned offs;
        logic [7:0]  b;
        logic [15:0] code;
        logic [2:0]  kind;
        b   = it.text_byte;
        x   = pen_x;
        y   = pen_y;
        cmd = '0;
        if (it.op == OP_START)
        begin
            org_x     = it.start_x;
            org_y     = it.start_y;
            pen_x     = it.start_x;
            pen_y     = it.start_y;
            lead_held = 1'b0;
            drop_next = 1'b0;
            stopped   = 1'b0;
            return 1'b0;
        end
        if (stopped)
            return 1'b0;
        // A zero byte ends the string wherever it falls, even as a trail byte.
        if (b == CHAR_NUL)
        begin
            stopped   = 1'b1;
            lead_held = 1'b0;
            drop_next = 1'b0;
            return 1'b0;
        end
        if (drop_next)
        begin
            drop_next = 1'b0;
            return 1'b0;
        end
        if (!lead_held)
        begin
            if (b > ASCII_MAX)
            begin
                lead_held = 1'b1;
                lead_val  = b;
                return 1'b0;
            end
            if (wrap_hits_bottom(lay_font / 2, x, y))
            begin
                stopped = 1'b1;
                cmd = draw_cmd(KIND_STOPPED, x, y, {8'h00, b}, 0, 0);
                return 1'b1;
            end
            if (b == CHAR_CR)
            begin
                pen_x     = org_x;
                pen_y     = CUR_BITS'(y + lay_font);
                drop_next = 1'b1;
                return 1'b0;
            end
            cmd   = draw_cmd(KIND_ASCII, x, y, {8'h00, b}, 0, 0);
            pen_x = CUR_BITS'(x + lay_font / 2);
            pen_y = CUR_BITS'(y);
            return 1'b1;
        end
        code      = {lead_val, b};
        lead_held = 1'b0;
        if (wrap_hits_bottom(lay_font, x, y))
        begin
            stopped = 1'b1;
            cmd = draw_cmd(KIND_STOPPED, x, y, code, 0, 0);
            return 1'b1;
        end
        offs   = 0;
        nbytes = 0;
        if (lay_font != FONT_16 && lay_font != FONT_24 && lay_font != FONT_32)
            kind = KIND_UNSUPPORTED;
        else if (lead_val < LEAD_MIN || b < TRAIL_MIN || b == CODE_BAD
                 || lead_val == CODE_BAD)
            kind = KIND_INVALID;
        else
        begin
            // Trail bytes skip 0x7F, so those above it shift down by one.
            col    = (b < TRAIL_GAP) ? b - TRAIL_MIN : b - TRAIL_HI_BASE;
            nbytes = ((lay_font + 7) / 8) * lay_font;
            offs   = (GLYPHS_PER_ROW * (lead_val - LEAD_MIN) + col) * nbytes;
            kind   = KIND_GLYPH;
        end
        cmd   = draw_cmd(kind, x, y, code, offs, nbytes);
        pen_x = CUR_BITS'(x + lay_font);
        pen_y = CUR_BITS'(y);
        return 1'b1;
    endfunction

    // Offers one item, waits until it is taken and records what it should
    // produce. Every caller enters and leaves right after a rising edge.
    task automatic offer_item(input in_item_t it);
        out_item_t cmd;
        int        gap;
        gap = 0;
        if (!idle_off)
        begin
            if (sender_calm > 0)
                sender_calm--;
            else if ($urandom_range(0, 99) < 18)
                gap = $urandom_range(1, 13);
            else if ($urandom_range(0, 99) < 3)
                sender_calm = $urandom_range(20, 80);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        live_items++;
        if (layout_step(it, cmd))
            draws_due.push_back(cmd);
    endtask

    task automatic send_start(input int unsigned x, input int unsigned y);
        in_item_t it;
        it.op        = OP_START;
        it.start_x   = COORD_BITS'(x);
        it.start_y   = COORD_BITS'(y);
        it.text_byte = 8'($urandom_range(0, 255));
        offer_item(it);
    endtask

    // The origin fields are ignored with a text byte, so they carry noise.
    task automatic send_byte(input logic [7:0] b);
        in_item_t it;
        it.op        = OP_BYTE;
        it.start_x   = COORD_BITS'($urandom);
        it.start_y   = COORD_BITS'($urandom);
        it.text_byte = b;
        offer_item(it);
    endtask

    // Holds the input off until every predicted command has come out and
    // the block has had time to finish a command-free item.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (draws_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
        logic [COORD_BITS-1:0] v;
        v = COORD_BITS'(val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        case (idx)
            CFG_AREA_WIDTH:   lay_width   = v;
            CFG_AREA_HEIGHT:  lay_height  = v;
            CFG_FONT_SIZE:    lay_font    = v[FONT_BITS-1:0];
            CFG_OVERLAY_MODE: lay_overlay = v[0];
            default:          ;
        endcase
    endtask

    task automatic set_layout(input int unsigned width, input int unsigned height,
                              input int unsigned font, input logic overlay);
        settle_idle();
        write_reg(CFG_AREA_WIDTH, width);
        write_reg(CFG_AREA_HEIGHT, height);
        write_reg(CFG_FONT_SIZE, font);
        write_reg(CFG_OVERLAY_MODE, overlay);
        cfg_we <= 1'b0;
    endtask

    // One character of running text: mostly ASCII and well-formed GBK pairs,
    // with some broken codes, carriage returns and stray bytes mixed in.
    task automatic send_random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            send_byte(8'($urandom_range(1, ASCII_MAX)));
        else if (r < 75)
        begin
            send_byte(8'($urandom_range(LEAD_MIN, 8'hFE)));
            send_byte(8'($urandom_range(TRAIL_MIN, 8'hFE)));
        end
        else if (r < 85)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    send_byte(CODE_BAD);
                    send_byte(8'($urandom_range(1, 255)));
                end
                1:
                begin
                    send_byte(8'($urandom_range(LEAD_MIN, 255)));
                    send_byte(8'($urandom_range(1, TRAIL_MIN - 1)));
                end
                default:
                begin
                    send_byte(8'($urandom_range(LEAD_MIN, 255)));
                    send_byte(CODE_BAD);
                end
            endcase
        end
        else if (r < 93)
        begin
            send_byte(CHAR_CR);
            send_byte(8'($urandom_range(1, 255)));
        end
        else
            send_byte(8'($urandom));
    endtask

    // A start item, a run of characters and usually a terminator. Now and
    // then a few raw items come first.
    task automatic send_random_string();
        in_item_t junk;
        int       r;
        if ($urandom_range(0, 99) < 6)
        begin
            repeat ($urandom_range(1, 3))
            begin
                junk = $bits(in_item_t)'($urandom);
                offer_item(junk);
            end
        end
        send_start($urandom_range(0, 2047), $urandom_range(0, 2047));
        repeat ($urandom_range(1, 28)) send_random_char();
        r = $urandom_range(0, 99);
        if (r < 65)
            send_byte(CHAR_NUL);
        else if (r < 75)
        begin
            send_byte(8'($urandom_range(LEAD_MIN, 255)));
            send_byte(CHAR_NUL);
        end
    endtask

    task automatic pick_layout();
        int unsigned w;
        int unsigned h;
        int unsigned f;
        case ($urandom_range(0, 9))
            0:       w = 0;
            1:       w = 2047;
            default: w = $urandom_range(16, 700);
        endcase
        case ($urandom_range(0, 9))
            0:       h = 0;
            1:       h = 2047;
            default: h = $urandom_range(16, 400);
        endcase
        if ($urandom_range(0, 9) < 6)
        begin
            case ($urandom_range(0, 2))
                0:       f = FONT_16;
                1:       f = FONT_24;
                default: f = FONT_32;
            endcase
        end
        else
            f = $urandom_range(1, 32);
        set_layout(w, h, f, 1'($urandom_range(0, 1)));
    endtask

    // Text before the first start item must be ignored.
    task automatic test_reset_state();
        send_byte(8'h51);
    endtask

    // Character codes at the default layout: range ends of ASCII and GBK, invalid
    // codes with a lead of 0xFF or a trail below 0x40, carriage returns and early terminators.
    task automatic test_codes();
        send_start(2047, 0);
        send_byte(ASCII_MAX);
        // Lowest valid code gives offset zero, the highest the last glyph.
        send_byte(LEAD_MIN);
        send_byte(TRAIL_MIN);
        send_byte(8'hFE);
        send_byte(8'hFE);
        send_byte(CODE_BAD);
        send_byte(TRAIL_GAP);
        send_byte(8'h90);
        send_byte(8'(TRAIL_MIN - 1));
        // The byte after a carriage return is dropped, even a lead byte.
        send_byte(CHAR_CR);
        send_byte(8'hC1);
        send_byte(8'h01);
        // A zero right after a carriage return still ends the string.
        send_byte(CHAR_CR);
        send_byte(CHAR_NUL);
        send_byte(8'h42);
        // A zero in place of a trail byte ends the string and loses the lead.
        send_start(0, 2047);
        send_byte(LEAD_MIN);
        send_byte(CHAR_NUL);
        send_byte(8'h43);
    endtask

    // A zero font size still draws ASCII, and any glyph is unsupported.
    task automatic test_zero_font();
        set_layout(0, 2047, 0, 1'b1);
        send_start(100, 50);
        send_byte(8'h41);
        send_byte(8'hB0);
        send_byte(8'hA1);
    endtask

    // One character fits the line; the next wraps and falls off the bottom.
    task automatic test_wrap_bottom();
        set_layout(8, 16, FONT_16, 1'b1);
        send_start(10, 20);
        send_byte(8'h61);
        send_byte(8'h62);
        send_byte(8'h63);
    endtask

    task automatic test_random_text();
        int goal;
        goal = live_items + RANDOM_ITEMS;
        while (live_items < goal)
        begin
            pick_layout();
            repeat (6) send_random_string();
        end
    endtask

    // Full rate on both sides to close the run.
    task automatic test_back_to_back();
        int goal;
        set_layout(AREA_WIDTH_RESET, AREA_HEIGHT_RESET, FONT_24, 1'b0);
        idle_off = 1'b1;
        goal = live_items + TAIL_ITEMS;
        while (live_items < goal)
            send_random_string();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Output side: stalls in random bursts, with calm stretches in between.
    always @(posedge clk)
    begin
        if (idle_off)
            out_ready <= 1'b1;
        else if (ready_stall > 0)
        begin
            out_ready   <= 1'b0;
            ready_stall <= ready_stall - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (ready_calm > 0)
                ready_calm <= ready_calm - 1;
            else if ($urandom_range(0, 99) < 12)
                ready_stall <= $urandom_range(1, 13);
            else if ($urandom_range(0, 99) < 3)
                ready_calm <= $urandom_range(30, 120);
        end
    end

    // Every draw command taken is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (draws_due.size() == 0)
            begin
                $error("unexpected draw command: kind %0d, char_code %0h",
                       out_item.kind, out_item.char_code);
                errors++;
            end
            else
            begin
                due = draws_due.pop_front();
                check_field("kind", due.kind, out_item.kind);
                check_field("draw_x", due.draw_x, out_item.draw_x);
                check_field("draw_y", due.draw_y, out_item.draw_y);
                check_field("char_code", due.char_code, out_item.char_code);
                check_field("glyph_offset", due.glyph_offset, out_item.glyph_offset);
                check_field("glyph_bytes", due.glyph_bytes, out_item.glyph_bytes);
                check_field("overlay", due.overlay, out_item.overlay);
            end
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int waited;
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        out_ready   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_AREA_WIDTH;
        cfg_data    = '0;
        errors      = 0;
        live_items  = 0;
        cycles      = 0;
        idle_off    = 1'b0;
        sender_calm = 0;
        ready_stall = 0;
        ready_calm  = 0;
        reset_layout_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_codes();
        test_zero_font();
        test_wrap_bottom();
        test_random_text();
        test_back_to_back();

        // Drain whatever is still on its way, then allow a few more cycles so
        // that a stray extra command would still be caught.
        in_valid <= 1'b0;
        waited = 0;
        while (draws_due.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (draws_due.size() != 0)
        begin
            $error("%0d draw commands never arrived", draws_due.size());
            errors++;
        end
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
rtl/gtl_pkg.sv
rtl/gtl_ctrl.sv
rtl/gtl_datapath.sv
rtl/gbk_text_layout_engine.sv
rtl/gtl_checker.sv
tb/testbench.sv
